// ----- rtl/pacn_pkg.sv -----
`default_nettype none

package pacn_pkg;

  // default geometry of the axis
  localparam int ADC_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 15;

  // fixed register and timestamp widths
  localparam int DZ_BITS   = 12;
  localparam int TIME_BITS = 32;
  localparam int CMD_BITS  = 3;
  localparam int ADDR_BITS = 4;

  // register reset values
  localparam logic [DZ_BITS-1:0]   DZ_RESET  = DZ_BITS'(50);
  localparam logic [TIME_BITS-1:0] DUR_RESET = TIME_BITS'(3000);

  // register indexes on the configuration port
  localparam logic [ADDR_BITS-1:0] CFG_DEADZONE = ADDR_BITS'(0);
  localparam logic [ADDR_BITS-1:0] CFG_DURATION = ADDR_BITS'(1);

  // commands carried with each input beat
  typedef enum logic [CMD_BITS-1:0] {
    CMD_NORMALIZE = 3'd0,
    CMD_BEGIN     = 3'd1,
    CMD_UPDATE    = 3'd2,
    CMD_END       = 3'd3,
    CMD_LOAD      = 3'd4
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/pot_axis_calibrate_normalize.sv -----
`default_nettype none

// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tdata: sample, now_ms, load_min, load_max, load_center
//                                     tuser: command, apply_deadzone
// out_     out  out_tvalid/out_tready tdata: normalized, raw_value, calibration_done,
//                                     is_calibrating, center_value
// cfg_     in   cfg_valid/cfg_ready   cfg_addr register index, cfg_data value
//
// normalize beats pass S_DZ, S_ND, S_MAG, S_DIV and S_FIN; S_DIV waits on the
// bit-serial divider producing one quotient bit per cycle.
// other commands, and normalize beats on the center or in the deadzone, skip S_MAG and S_DIV.
// one beat is in work at a time; the next beat is accepted while a finished result
// still waits in the output register, and a second result holds in S_FIN until taken.
// rst_n is synchronous, active low; cfg_ready is always high.
module pot_axis_calibrate_normalize #(
  parameter int ADC_BITS  = pacn_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = pacn_pkg::FRAC_BITS_DEF,
  parameter int IN_W      = ((4 * ADC_BITS + pacn_pkg::TIME_BITS + 7) / 8) * 8,
  parameter int OUT_W     = ((FRAC_BITS + 1 + 2 * ADC_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: sample, now_ms, load_min, load_max, load_center (lowest bits first)
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [IN_W-1:0]                in_tdata,
  // in_tuser: command [2:0], apply_deadzone [3]
  input  wire logic [3:0]                     in_tuser,
  // out_tdata: normalized, raw_value, calibration_done, is_calibrating,
  // center_value (lowest bits first)
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [OUT_W-1:0]                    out_tdata,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pacn_pkg::ADDR_BITS-1:0] cfg_addr,
  input  wire logic [pacn_pkg::TIME_BITS-1:0] cfg_data
);

  localparam int A      = ADC_BITS;
  localparam int TW     = pacn_pkg::TIME_BITS;
  localparam int DZW    = pacn_pkg::DZ_BITS;
  localparam int NW     = FRAC_BITS + 1;
  localparam int OUT_DW = NW + 2 * A + 2;
  localparam int DCW    = (A > DZW) ? A : DZW;
  localparam int DONE_BIT = NW + A;
  localparam int CAL_BIT  = NW + A + 1;

  localparam logic [NW-1:0] MINV = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [NW-1:0] MAXV = {1'b0, {FRAC_BITS{1'b1}}};
  localparam logic [A-1:0]  MAX_RESET = {A{1'b1}};
  localparam logic [A-1:0]  CTR_RESET = {1'b1, {(A - 1){1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DZ   = 6'b000010,
    S_ND   = 6'b000100,
    S_MAG  = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // captured beat
  pacn_pkg::cmd_t cmd_r, cmd_nxt;
  logic [A-1:0]   smp_r, smp_nxt;
  logic           dz_r, dz_nxt;
  logic [TW-1:0]  now_r, now_nxt;
  logic [A-1:0]   lmin_r, lmin_nxt;
  logic [A-1:0]   lmax_r, lmax_nxt;
  logic [A-1:0]   lctr_r, lctr_nxt;

  // registers
  logic [DZW-1:0] dw_r, dw_nxt;
  logic [TW-1:0]  dur_r, dur_nxt;

  // calibration state
  logic [A-1:0]   min_r, min_nxt;
  logic [A-1:0]   max_r, max_nxt;
  logic [A-1:0]   ctr_r, ctr_nxt;
  logic           act_r, act_nxt;
  logic [TW-1:0]  start_r, start_nxt;

  // per-beat working values
  logic           zero_r, zero_nxt;
  logic           below_r, below_nxt;
  logic           fin_r, fin_nxt;
  logic           done_r, done_nxt;
  logic [A:0]     num_r, num_nxt;
  logic [A:0]     den_r, den_nxt;
  logic [A-1:0]   nabs_r, nabs_nxt;
  logic [A-1:0]   dabs_r, dabs_nxt;
  logic           neg_r, neg_nxt;
  logic           dzero_r, dzero_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;

  // divider link
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic          div_ovf;

  // combinational helpers
  logic [A-1:0]  absd;
  logic          snap;
  logic [TW-1:0] elapsed;
  logic          tmo;
  logic [A:0]    mm_sum;
  logic [A:0]    nneg, dneg;
  logic          qbig;
  logic [NW-1:0] qneg;
  logic [NW-1:0] norm;

  pacn_div #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (nabs_r),
    .den   (dabs_r),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // deadzone, timeout and midpoint terms
  always_comb begin
    absd    = (smp_r >= ctr_r) ? (smp_r - ctr_r) : (ctr_r - smp_r);
    snap    = dz_r && (DCW'(absd) < DCW'(dw_r));
    elapsed = now_r - start_r;
    tmo     = elapsed >= dur_r;
    mm_sum  = {1'b0, min_r} + {1'b0, max_r};
    nneg    = '0 - num_r;
    dneg    = '0 - den_r;
  end

  // final mapping and saturation
  always_comb begin
    qbig = div_ovf | div_quo[FRAC_BITS];
    qneg = '0 - div_quo;
    if (cmd_r != pacn_pkg::CMD_NORMALIZE || zero_r) begin
      norm = '0;
    end else if (below_r) begin
      if (dzero_r || neg_r) norm = MINV;
      else if (div_ovf)     norm = MAXV;
      else                  norm = {~div_quo[FRAC_BITS], div_quo[FRAC_BITS-1:0]};
    end else begin
      if (dzero_r)     norm = MAXV;
      else if (neg_r)  norm = qbig ? MINV : qneg;
      else             norm = qbig ? MAXV : div_quo;
    end
  end

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    smp_nxt       = smp_r;
    dz_nxt        = dz_r;
    now_nxt       = now_r;
    lmin_nxt      = lmin_r;
    lmax_nxt      = lmax_r;
    lctr_nxt      = lctr_r;
    dw_nxt        = dw_r;
    dur_nxt       = dur_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ctr_nxt       = ctr_r;
    act_nxt       = act_r;
    start_nxt     = start_r;
    zero_nxt      = zero_r;
    below_nxt     = below_r;
    fin_nxt       = fin_r;
    done_nxt      = done_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    nabs_nxt      = nabs_r;
    dabs_nxt      = dabs_r;
    neg_nxt       = neg_r;
    dzero_nxt     = dzero_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // configuration writes
    if (cfg_valid) begin
      case (cfg_addr)
        pacn_pkg::CFG_DEADZONE: dw_nxt  = cfg_data[DZW-1:0];
        pacn_pkg::CFG_DURATION: dur_nxt = cfg_data;
        default: ;
      endcase
    end

    // output beat taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = pacn_pkg::cmd_t'(in_tuser[2:0]);
          dz_nxt    = in_tuser[3];
          smp_nxt   = in_tdata[A-1:0];
          now_nxt   = in_tdata[A+TW-1:A];
          lmin_nxt  = in_tdata[2*A+TW-1:A+TW];
          lmax_nxt  = in_tdata[3*A+TW-1:2*A+TW];
          lctr_nxt  = in_tdata[4*A+TW-1:3*A+TW];
          state_nxt = S_DZ;
        end
      end
      S_DZ: begin
        zero_nxt  = snap || (smp_r == ctr_r);
        below_nxt = smp_r < ctr_r;
        fin_nxt   = 1'b0;
        done_nxt  = 1'b0;
        case (cmd_r)
          pacn_pkg::CMD_BEGIN: begin
            act_nxt   = 1'b1;
            start_nxt = now_r;
            min_nxt   = smp_r;
            max_nxt   = smp_r;
          end
          pacn_pkg::CMD_UPDATE: begin
            if (act_r) begin
              if (smp_r < min_r) min_nxt = smp_r;
              if (smp_r > max_r) max_nxt = smp_r;
              fin_nxt  = tmo;
              done_nxt = tmo;
            end
          end
          pacn_pkg::CMD_END: begin
            fin_nxt = act_r;
          end
          pacn_pkg::CMD_LOAD: begin
            min_nxt = lmin_r;
            max_nxt = lmax_r;
            ctr_nxt = lctr_r;
            act_nxt = 1'b0;
          end
          default: ;
        endcase
        state_nxt = S_ND;
      end
      S_ND: begin
        // finish a run, or form numerator and denominator of the mapping
        if (fin_r) begin
          ctr_nxt = mm_sum[A:1];
          act_nxt = 1'b0;
        end
        if (below_r) begin
          num_nxt = {1'b0, smp_r} - {1'b0, min_r};
          den_nxt = {1'b0, ctr_r} - {1'b0, min_r};
        end else begin
          num_nxt = {1'b0, smp_r} - {1'b0, ctr_r};
          den_nxt = {1'b0, max_r} - {1'b0, ctr_r};
        end
        state_nxt = (cmd_r == pacn_pkg::CMD_NORMALIZE && !zero_r) ? S_MAG : S_FIN;
      end
      S_MAG: begin
        nabs_nxt  = num_r[A] ? nneg[A-1:0] : num_r[A-1:0];
        dabs_nxt  = den_r[A] ? dneg[A-1:0] : den_r[A-1:0];
        neg_nxt   = num_r[A] ^ den_r[A];
        dzero_nxt = den_r == '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ctr_r, act_r, done_r, smp_r, norm};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // magnitudes are registered in S_MAG, divider starts the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dw_r        <= pacn_pkg::DZ_RESET;
      dur_r       <= pacn_pkg::DUR_RESET;
      min_r       <= '0;
      max_r       <= MAX_RESET;
      ctr_r       <= CTR_RESET;
      act_r       <= 1'b0;
      start_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dw_r        <= dw_nxt;
      dur_r       <= dur_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ctr_r       <= ctr_nxt;
      act_r       <= act_nxt;
      start_r     <= start_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    smp_r      <= smp_nxt;
    dz_r       <= dz_nxt;
    now_r      <= now_nxt;
    lmin_r     <= lmin_nxt;
    lmax_r     <= lmax_nxt;
    lctr_r     <= lctr_nxt;
    zero_r     <= zero_nxt;
    below_r    <= below_nxt;
    fin_r      <= fin_nxt;
    done_r     <= done_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    nabs_r     <= nabs_nxt;
    dabs_r     <= dabs_nxt;
    neg_r      <= neg_nxt;
    dzero_r    <= dzero_nxt;
    out_data_r <= out_data_nxt;
  end

  // launch the divider when entering S_DIV
  logic div_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else        div_go_r <= (state_r == S_MAG);
  end

  assign in_tready  = state_r == S_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // divider start pulse, in the cycle after S_MAG, as the registered magnitudes appear
  assign div_start = div_go_r;

  // checks
  a_accept_to_dz: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DZ))
    else $error("accepted beat did not start processing");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (min_r <= max_r))
    else $error("active calibration run with minimum above maximum");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[DONE_BIT]) |-> !out_tdata[CAL_BIT])
    else $error("calibration reported done while still active");

endmodule

`default_nettype wire

// ----- rtl/pacn_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle, msb first
// quo = floor(num * 2^FRAC_BITS / den) when ovf is low
// ovf flags a quotient of 2^(FRAC_BITS+1) or more
module pacn_div #(
  parameter int ADC_BITS  = pacn_pkg::ADC_BITS_DEF,
  parameter int FRAC_BITS = pacn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [ADC_BITS-1:0]  num,
  input  wire logic [ADC_BITS-1:0]  den,
  output logic                      done,
  output logic [FRAC_BITS:0]        quo,
  output logic                      ovf
);

  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic [CW-1:0] LAST = CW'(FRAC_BITS);

  logic [ADC_BITS:0]   rem_r;
  logic [ADC_BITS-1:0] den_r;
  logic [FRAC_BITS:0]  quo_r;
  logic                ovf_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic [ADC_BITS:0] den_ext;
  logic [ADC_BITS:0] diff;
  logic [ADC_BITS:0] rem_step;
  logic              fits;

  // one trial subtraction per cycle
  always_comb begin
    den_ext  = {1'b0, den_r};
    fits     = rem_r >= den_ext;
    diff     = rem_r - den_ext;
    rem_step = fits ? diff : rem_r;
  end

  // control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      ovf_r <= {1'b0, num} >= {den, 1'b0};
      cnt_r <= LAST;
    end else if (busy_r) begin
      quo_r <= {quo_r[FRAC_BITS-1:0], fits};
      rem_r <= {rem_step[ADC_BITS-1:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

`default_nettype wire
